[src/lbhp_pkg.sv]
// Shared constants, register codes and types for the lane base histogram peak unit.
// No dependencies; every other file but lbhp_ram uses this package.
`timescale 1ns / 1ps
package lbhp_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    // Wide enough for any clamped dimension and any raw register value
    localparam int DIM_W      = 14;
    localparam int CFG_W      = 12;
    localparam int BAND_W     = 11;
    localparam int CNT_W      = 11;
    localparam int POS_W      = 11;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX          = '1;
    localparam logic [CFG_W-1:0]  WIDTH_RESET      = CFG_W'(640);
    localparam logic [CFG_W-1:0]  HEIGHT_RESET     = CFG_W'(480);
    localparam logic [BAND_W-1:0] BAND_RESET       = BAND_W'(264);

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BAND_HEIGHT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] mid;
        logic [DIM_W-1:0] first_row;
        logic [DIM_W-1:0] last_row;
    } limits_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             edge_bit;
        logic             in_band;
        logic             band_first;
        logic             band_last;
        logic             left_half;
        logic             col_zero;
        logic             col_mid;
        logic             col_end;
    } tag_t;

endpackage

[src/lbhp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lbhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/lbhp_cfg.sv]
// APB-style register file and derived frame limits (clamped width, height, band rows).
// Depends on lbhp_pkg.
`timescale 1ns / 1ps
module lbhp_cfg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [lbhp_pkg::ADDR_W-1:0] paddr,
    input  logic [lbhp_pkg::DATA_W-1:0] pwdata,
    output logic [lbhp_pkg::DATA_W-1:0] prdata,
    output lbhp_pkg::limits_t      limits
);
    import lbhp_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [BAND_W-1:0] band_reg;
    reg_idx_t          reg_idx;
    logic [DIM_W-1:0]  w_raw, h_raw, b_raw, w_clamp, h_clamp, h_less1, b_clamp;

    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            band_reg   <= BAND_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_BAND_HEIGHT:  band_reg   <= pwdata[BAND_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(height_reg);
            REG_BAND_HEIGHT:  prdata = DATA_W'(band_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        w_raw = DIM_W'(width_reg);
        h_raw = DIM_W'(height_reg);
        b_raw = DIM_W'(band_reg);

        if (w_raw < DIM_W'(2))
            w_clamp = DIM_W'(2);
        else if (w_raw > DIM_W'(MAX_WIDTH))
            w_clamp = DIM_W'(MAX_WIDTH);
        else
            w_clamp = w_raw;

        if (h_raw < DIM_W'(2))
            h_clamp = DIM_W'(2);
        else if (h_raw > DIM_W'(MAX_HEIGHT))
            h_clamp = DIM_W'(MAX_HEIGHT);
        else
            h_clamp = h_raw;

        // Band sits just above the last row, at most every row but that one
        h_less1 = h_clamp - DIM_W'(1);
        if (b_raw < DIM_W'(1))
            b_clamp = DIM_W'(1);
        else if (b_raw > h_less1)
            b_clamp = h_less1;
        else
            b_clamp = b_raw;

        limits.width     = w_clamp;
        limits.height    = h_clamp;
        limits.mid       = w_clamp >> 1;
        limits.first_row = h_less1 - b_clamp;
        limits.last_row  = h_clamp - DIM_W'(2);
    end

endmodule

[src/lbhp_scan.sv]
// Raster row and column counters; classifies the offered pixel against the band limits.
// Depends on lbhp_pkg.
`timescale 1ns / 1ps
module lbhp_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        edge_pixel,
    input  logic                        frame_start,
    input  lbhp_pkg::limits_t           limits,
    output lbhp_pkg::tag_t              tag,
    output logic [lbhp_pkg::COL_W-1:0]  rd_addr
);
    import lbhp_pkg::*;

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [DIM_W-1:0] col_ext, row_ext;
    logic             col_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        // A frame start pixel is taken as row 0, column 0
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        col_ext  = DIM_W'(col_cur);
        row_ext  = DIM_W'(row_cur);
        col_last = (col_ext + DIM_W'(1)) >= limits.width;

        tag.col        = col_cur;
        tag.edge_bit   = edge_pixel;
        tag.in_band    = (col_ext < limits.width) && (row_ext >= limits.first_row)
                         && (row_ext <= limits.last_row);
        tag.band_first = (row_ext == limits.first_row);
        tag.band_last  = (row_ext == limits.last_row);
        tag.left_half  = (col_ext < limits.mid);
        tag.col_zero   = (col_cur == '0);
        tag.col_mid    = (col_ext == limits.mid);
        tag.col_end    = col_last;
        rd_addr        = col_cur;

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                if ((row_ext + DIM_W'(1)) >= limits.height)
                    row_next = '0;
                else
                    row_next = ROW_W'(row_ext + DIM_W'(1));
            end
            else
            begin
                col_next = COL_W'(col_ext + DIM_W'(1));
                row_next = row_cur;
            end
        end
    end

endmodule

[src/lbhp_peak.sv]
// Count update stage, per-half peak tracking and the result register.
// Depends on lbhp_pkg; column counts come from and return to an lbhp_ram in the top level.
`timescale 1ns / 1ps
module lbhp_peak (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  lbhp_pkg::tag_t              tag,
    input  logic [lbhp_pkg::CNT_W-1:0]  rd_data,
    output logic                        hold,
    output logic                        wr_en,
    output logic [lbhp_pkg::COL_W-1:0]  wr_addr,
    output logic [lbhp_pkg::CNT_W-1:0]  wr_data,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [lbhp_pkg::POS_W-1:0]  left_position,
    output logic [lbhp_pkg::CNT_W-1:0]  left_peak_count,
    output logic [lbhp_pkg::POS_W-1:0]  right_position,
    output logic [lbhp_pkg::CNT_W-1:0]  right_peak_count
);
    import lbhp_pkg::*;

    logic             s1_valid_reg;
    tag_t             s1_tag_reg;
    logic [COL_W-1:0] best_lcol_reg, best_lcol_next, best_rcol_reg, best_rcol_next;
    logic [CNT_W-1:0] best_lcnt_reg, best_lcnt_next, best_rcnt_reg, best_rcnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_lpos_reg, out_rpos_reg;
    logic [CNT_W-1:0] out_lcnt_reg, out_rcnt_reg;
    logic             emit, advance;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] val;

    always_comb
    begin
        emit    = s1_tag_reg.in_band && s1_tag_reg.band_last && s1_tag_reg.col_end;
        // Hold the stage only when a new result meets a result still waiting
        advance = s1_valid_reg && !(emit && out_valid_reg && out_stall);
        hold    = s1_valid_reg && !advance;

        sum = (CNT_W+1)'(rd_data) + (CNT_W+1)'(s1_tag_reg.edge_bit);
        if (s1_tag_reg.band_first)
            val = CNT_W'(s1_tag_reg.edge_bit);
        else if (sum > (CNT_W+1)'(CNT_MAX))
            val = CNT_MAX;
        else
            val = sum[CNT_W-1:0];

        wr_en   = advance && s1_tag_reg.in_band;
        wr_addr = s1_tag_reg.col;
        wr_data = val;

        best_lcol_next = best_lcol_reg;
        best_lcnt_next = best_lcnt_reg;
        best_rcol_next = best_rcol_reg;
        best_rcnt_next = best_rcnt_reg;
        if (advance && s1_tag_reg.in_band && s1_tag_reg.band_last)
        begin
            // Strictly greater replaces, so the first column reached keeps a tie
            if (s1_tag_reg.left_half)
            begin
                if (s1_tag_reg.col_zero || val > best_lcnt_reg)
                begin
                    best_lcol_next = s1_tag_reg.col;
                    best_lcnt_next = val;
                end
            end
            else if (s1_tag_reg.col_mid || val > best_rcnt_reg)
            begin
                best_rcol_next = s1_tag_reg.col;
                best_rcnt_next = val;
            end
        end

        if (advance && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            best_lcol_reg <= '0;
            best_lcnt_reg <= '0;
            best_rcol_reg <= '0;
            best_rcnt_reg <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
            best_lcol_reg <= best_lcol_next;
            best_lcnt_reg <= best_lcnt_next;
            best_rcol_reg <= best_rcol_next;
            best_rcnt_reg <= best_rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_tag_reg <= tag;
        if (advance && emit)
        begin
            out_lpos_reg <= POS_W'(best_lcol_next);
            out_lcnt_reg <= best_lcnt_next;
            out_rpos_reg <= POS_W'(best_rcol_next);
            out_rcnt_reg <= best_rcnt_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign left_position    = out_lpos_reg;
    assign left_peak_count  = out_lcnt_reg;
    assign right_position   = out_rpos_reg;
    assign right_peak_count = out_rcnt_reg;

endmodule

[src/lane_base_histogram_peaks_unit.sv]
// Accepted pixel items are registered in the count update stage; a result item is registered on the
// output as the last pixel item of its band row leaves it. Throughput: one pixel item per cycle
// unless stalled; the column count read-modify-write uses one RAM read port and one write port, and
// one result item is produced per frame. The input stalls only while a finished result waits and the
// next one is ready. Reset: asynchronous, active low; clears counters, peaks, valids and registers to
// 640 x 480 with a 264-row band. Column counts are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module lane_base_histogram_peaks_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbhp_pkg::ADDR_W-1:0] paddr,
    input  logic [lbhp_pkg::DATA_W-1:0] pwdata,
    output logic [lbhp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        edge_pixel,
    input  logic                        frame_start,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lbhp_pkg::POS_W-1:0]  left_position,
    output logic [lbhp_pkg::CNT_W-1:0]  left_peak_count,
    output logic [lbhp_pkg::POS_W-1:0]  right_position,
    output logic [lbhp_pkg::CNT_W-1:0]  right_peak_count
);
    import lbhp_pkg::*;

    limits_t          limits;
    tag_t             tag;
    logic             accept, hold, wr_en;
    logic [COL_W-1:0] rd_addr, wr_addr;
    logic [CNT_W-1:0] rd_data, wr_data;

    assign pready   = 1'b1;
    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    lbhp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .limits  (limits)
    );

    lbhp_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .edge_pixel  (edge_pixel),
        .frame_start (frame_start),
        .limits      (limits),
        .tag         (tag),
        .rd_addr     (rd_addr)
    );

    lbhp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_counts (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lbhp_peak u_peak (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .tag              (tag),
        .rd_data          (rd_data),
        .hold             (hold),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .left_position    (left_position),
        .left_peak_count  (left_peak_count),
        .right_position   (right_position),
        .right_peak_count (right_peak_count)
    );

endmodule

[src/lbhp_checker.sv]
// Port-level checks on the lane base histogram peak unit, bound to the top level.
// Depends on lbhp_pkg and lane_base_histogram_peaks_unit.
`timescale 1ns / 1ps
module lbhp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [lbhp_pkg::POS_W-1:0]  left_position,
    input  logic [lbhp_pkg::CNT_W-1:0]  left_peak_count,
    input  logic [lbhp_pkg::POS_W-1:0]  right_position,
    input  logic [lbhp_pkg::CNT_W-1:0]  right_peak_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_position) && $stable(left_peak_count)
                                   && $stable(right_position) && $stable(right_peak_count))
        else $error("stalled result item changed");

    // Left peak lies below mid, right peak at or above it
    a_halves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_position < right_position)
        else $error("left peak not left of right peak");

    // Input backpressure only comes from a result waiting at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

endmodule

bind lane_base_histogram_peaks_unit lbhp_checker u_lbhp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .left_position    (left_position),
    .left_peak_count  (left_peak_count),
    .right_position   (right_position),
    .right_peak_count (right_peak_count)
);

[dv/lane_base_histogram_peaks_unit_tb.sv]
// Self-checking testbench for the lane base histogram peak unit: drives pixel items, programs
// the frame registers over APB and checks every peak result. Depends on lbhp_pkg and the RTL.
`timescale 1ns / 1ps
module lane_base_histogram_peaks_unit_tb;
    import lbhp_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] left_pos;
        logic [CNT_W-1:0] left_cnt;
        logic [POS_W-1:0] right_pos;
        logic [CNT_W-1:0] right_cnt;
    } peak_t;

    // Tracks column counts and the running peaks of both halves, and holds the peak results
    // that the block still owes.
    class peak_tracker;
        int unsigned      width_reg;
        int unsigned      height_reg;
        int unsigned      band_reg;
        logic [CNT_W-1:0] col_count [MAX_WIDTH];
        int unsigned      row_idx;
        int unsigned      col_idx;
        int unsigned      best_l_col;
        int unsigned      best_l_cnt;
        int unsigned      best_r_col;
        int unsigned      best_r_cnt;
        peak_t            pending_peaks [$];
        int unsigned      peaks_predicted;
        int unsigned      results_seen;
        int unsigned      mismatches;

        function new();
            width_reg = 640;
            height_reg = 480;
            band_reg = 264;
            foreach (col_count[i]) col_count[i] = '0;
            row_idx = 0;
            col_idx = 0;
            best_l_col = 0;
            best_l_cnt = 0;
            best_r_col = 0;
            best_r_cnt = 0;
            peaks_predicted = 0;
            results_seen = 0;
            mismatches = 0;
        endfunction

        function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return clip(width_reg, 2, MAX_WIDTH) * clip(height_reg, 2, MAX_HEIGHT);
        endfunction

        function void write_reg(reg_idx_t idx, int unsigned value);
            case (idx)
                REG_FRAME_WIDTH:  width_reg = value & ((1 << CFG_W) - 1);
                REG_FRAME_HEIGHT: height_reg = value & ((1 << CFG_W) - 1);
                REG_BAND_HEIGHT:  band_reg = value & ((1 << BAND_W) - 1);
                default: ;
            endcase
        endfunction

        function void take_pixel(logic edge_bit, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned band;
            int unsigned first_row;
            int unsigned last_row;
            int unsigned mid;
            int unsigned val;
            peak_t       res;
            w = clip(width_reg, 2, MAX_WIDTH);
            h = clip(height_reg, 2, MAX_HEIGHT);
            band = clip(band_reg, 1, h - 1);
            first_row = h - 1 - band;
            last_row = h - 2;
            mid = w >> 1;
            if (fs) begin
                row_idx = 0;
                col_idx = 0;
            end
            if (col_idx < w && row_idx >= first_row && row_idx <= last_row) begin
                if (row_idx == first_row) begin
                    val = 32'(edge_bit);
                end
                else begin
                    val = 32'(col_count[col_idx]) + 32'(edge_bit);
                    if (val > 32'(CNT_MAX)) val = 32'(CNT_MAX);
                end
                col_count[col_idx] = CNT_W'(val);
                if (row_idx == last_row) begin
                    // strictly greater replaces, so the first column wins a tie
                    if (col_idx < mid) begin
                        if (col_idx == 0 || val > best_l_cnt) begin
                            best_l_col = col_idx;
                            best_l_cnt = val;
                        end
                    end
                    else if (col_idx == mid || val > best_r_cnt) begin
                        best_r_col = col_idx;
                        best_r_cnt = val;
                    end
                    if (col_idx == w - 1) begin
                        res.left_pos = POS_W'(best_l_col);
                        res.left_cnt = CNT_W'(best_l_cnt);
                        res.right_pos = POS_W'(best_r_col);
                        res.right_cnt = CNT_W'(best_r_cnt);
                        pending_peaks.insert(pending_peaks.size(), res);
                        peaks_predicted++;
                    end
                end
            end
            if (col_idx + 1 >= w) begin
                col_idx = 0;
                row_idx = (row_idx + 1 >= h) ? 0 : row_idx + 1;
            end
            else begin
                col_idx++;
            end
        endfunction

        function void check_peaks(peak_t got);
            peak_t want;
            results_seen++;
            if (pending_peaks.size() == 0) begin
                $error("peak result with none expected: %0d/%0d %0d/%0d",
                       got.left_pos, got.left_cnt, got.right_pos, got.right_cnt);
                mismatches++;
                return;
            end
            want = pending_peaks.pop_front();
            if (got.left_pos !== want.left_pos) begin
                $error("left_position: expected %0d, got %0d", want.left_pos, got.left_pos);
                mismatches++;
            end
            if (got.left_cnt !== want.left_cnt) begin
                $error("left_peak_count: expected %0d, got %0d", want.left_cnt, got.left_cnt);
                mismatches++;
            end
            if (got.right_pos !== want.right_pos) begin
                $error("right_position: expected %0d, got %0d", want.right_pos, got.right_pos);
                mismatches++;
            end
            if (got.right_cnt !== want.right_cnt) begin
                $error("right_peak_count: expected %0d, got %0d", want.right_cnt,
                       got.right_cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              edge_pixel;
    logic              frame_start;
    logic              out_valid;
    logic              out_stall;
    logic [POS_W-1:0]  left_position;
    logic [CNT_W-1:0]  left_peak_count;
    logic [POS_W-1:0]  right_position;
    logic [CNT_W-1:0]  right_peak_count;

    peak_tracker tracker = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned pixels_sent = 0;
    int unsigned settings_used = 0;

    lane_base_histogram_peaks_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .edge_pixel       (edge_pixel),
        .frame_start      (frame_start),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .left_position    (left_position),
        .left_peak_count  (left_peak_count),
        .right_position   (right_position),
        .right_peak_count (right_peak_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.take_pixel(edge_pixel, frame_start);
        if (rst_n && out_valid && !out_stall)
            tracker.check_peaks({left_position, left_peak_count, right_position,
                                 right_peak_count});
    end

    // Receiver: random stalls, or a long hold-off on request so the block backs up.
    initial
    begin : receiver
        int hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("lane_base_histogram_peaks_unit regression: fail");
        $finish;
    end

    task automatic send_pixel(logic e, logic fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        edge_pixel <= e;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pixels_sent++;
    endtask

    // Wait out every owed result, then the pipeline depth for items with no result.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        while (tracker.pending_peaks.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (tracker.pending_peaks.size() != 0)
        begin
            $error("%0d peak results never arrived", tracker.pending_peaks.size());
            tracker.mismatches++;
            tracker.pending_peaks.delete();
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic program_reg(reg_idx_t idx, int unsigned value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] want;
        want = (idx == REG_BAND_HEIGHT) ? value & ((1 << BAND_W) - 1)
                                        : value & ((1 << CFG_W) - 1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(int'(idx) * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== want)
        begin
            $error("register %s: expected %0d, got %0d", idx.name(), want, readback);
            tracker.mismatches++;
        end
    endtask

    task automatic program_limits(int unsigned w, int unsigned h, int unsigned b);
        drain_results();
        program_reg(REG_FRAME_WIDTH, w);
        program_reg(REG_FRAME_HEIGHT, h);
        program_reg(REG_BAND_HEIGHT, b);
        @(posedge clk);
        settings_used++;
    endtask

    task automatic send_frame(int density, logic with_fs);
        int unsigned n;
        int unsigned d;
        n = tracker.frame_pixels();
        if (density >= 0)
            d = density;
        else
            case ($urandom_range(3))
                0: d = 0;
                1: d = 100;
                default: d = $urandom_range(100);
            endcase
        for (int unsigned i = 0; i < n; i++)
            send_pixel($urandom_range(99) < d, with_fs && i == 0);
    endtask

    // Mostly whole frames with random content; the rest noise that breaks frames apart.
    task automatic run_phase(int unsigned w, int unsigned h, int unsigned b,
                             int unsigned n_items, int first_density);
        int unsigned start;
        program_limits(w, h, b);
        start = pixels_sent;
        send_frame(first_density, 1'b1);
        while (pixels_sent - start < n_items)
        begin
            if ($urandom_range(99) < 80)
                send_frame(-1, $urandom_range(9) != 0);
            else
                repeat ($urandom_range(1, tracker.frame_pixels()))
                    send_pixel(1'($urandom_range(1)), $urandom_range(99) < 8);
        end
    endtask

    task automatic set_idle(int unsigned s, int unsigned r);
        send_idle_pct = s;
        recv_idle_pct = r;
    endtask

    initial
    begin
        logic [11:0] small_frames;
        logic [11:0] tie_frame;
        int unsigned peaks_start;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        edge_pixel = 1'b0;
        frame_start = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: three 2x2 frames, the later two entered by row wrap alone
        set_idle(15, 46);
        small_frames = 12'b1111_1110_0001;
        program_limits(2, 2, 1);
        for (int i = 0; i < 12; i++)
            send_pixel(small_frames[i], i == 0);
        // Directed: over-tall band starting at row 0, ties in both halves
        tie_frame = 12'b0110_1110_1101;
        program_limits(4, 3, 2047);
        for (int i = 0; i < 12; i++)
            send_pixel(tie_frame[i], i == 0);

        run_phase(0, 1, 0, 25, -1);
        run_phase(3, 4, 2, 25, -1);
        run_phase(5, 3, 2047, 25, -1);
        set_idle(46, 15);
        run_phase(4, 5, 1, 25, -1);
        run_phase(7, 4, 3, 25, -1);
        run_phase(2, 6, 4, 25, -1);
        set_idle(0, 0);
        run_phase(6, 3, 1, 25, -1);
        run_phase(9, 5, 2, 25, -1);

        // Shrink the frame while the indices sit beyond it, then let them wrap
        program_limits(8, 6, 2);
        send_frame(-1, 1'b1);
        repeat (47) send_pixel(1'($urandom_range(1)), 1'b0);
        program_limits(4, 4, 2);
        repeat (49) send_pixel(1'($urandom_range(1)), 1'b0);

        // Hold the output off while tiny frames keep coming in
        program_limits(2, 2, 1);
        hold_req = 1'b1;
        repeat (20) send_frame(-1, 1'b1);

        set_idle(15, 46);
        program_limits(2, 3, 1);
        peaks_start = tracker.peaks_predicted;
        while (tracker.peaks_predicted - peaks_start < 20)
            send_frame(-1, $urandom_range(3) != 0);

        drain_results();
        $display("Covered %0d pixel items, %0d peak results over %0d frame settings,",
                 pixels_sent, tracker.results_seen, settings_used);
        $display("with clamped limits, ties, resize wrap and a long output hold-off.");
        if (tracker.mismatches == 0)
            $display("lane_base_histogram_peaks_unit regression: pass");
        else
            $display("lane_base_histogram_peaks_unit regression: fail");
        $finish;
    end
endmodule

[sim.f]
src/lbhp_pkg.sv
src/lbhp_ram.sv
src/lbhp_cfg.sv
src/lbhp_scan.sv
src/lbhp_peak.sv
src/lane_base_histogram_peaks_unit.sv
src/lbhp_checker.sv
dv/lane_base_histogram_peaks_unit_tb.sv
